### hdl/tlik_pkg.sv
`default_nettype none
package tlik_pkg;

  // Field and datapath widths
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int ANG_BITS         = 30;
  localparam int ANG_W            = 34;   // Q30 angle word
  localparam int IN_W             = 20;
  localparam int OUT_W            = 21;
  localparam int POS_W            = 22;   // shifted x, y
  localparam int R2_W             = 42;   // squared radius
  localparam int ROOT_W           = R2_W / 2;
  localparam int CORD_IN_W        = 22;
  localparam int CORD_W           = 50;
  localparam int CORD_PRE         = 24;   // operand prescale shift

  // Register indexes
  localparam logic [2:0] REG_SEG_LEN   = 3'd0;
  localparam logic [2:0] REG_TOOL_LEN  = 3'd1;
  localparam logic [2:0] REG_FRONT_OFF = 3'd2;
  localparam logic [2:0] REG_SHOULDER  = 3'd3;
  localparam logic [2:0] REG_ANG_OFF   = 3'd4;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [18:0] SEG_LEN_RST = 19'd32768;

  // Arctangent of 2^-i in Q30, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] a;
    a = '0;
    case (i)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837830;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      default: begin
        if (i <= 30) a = 34'sd1 <<< (30 - i);
        else a = '0;
      end
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### hdl/tlik_sqrt.sv
`default_nettype none
// Pipelined floor square root, one root bit per stage
module tlik_sqrt (
  input  wire logic                         clk,
  input  wire logic                         ce,
  input  wire logic [tlik_pkg::R2_W-1:0]    rad,
  output logic      [tlik_pkg::ROOT_W-1:0]  root
);
  localparam int SW = tlik_pkg::ROOT_W;
  localparam int RW = tlik_pkg::R2_W;
  localparam int MW = SW + 2;

  logic [RW-1:0] rad_r  [SW];
  logic [MW-1:0] rem_r  [SW];
  logic [SW-1:0] root_r [SW];

  for (genvar j = 0; j < SW; j++) begin : g_stage
    logic [RW-1:0] rad_in;
    logic [MW-1:0] rem_in;
    logic [SW-1:0] root_in;
    logic [MW+1:0] part;
    logic [MW+1:0] trial;

    if (j == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    // bring down two radicand bits and try the next root bit
    assign part  = {rem_in, rad_in[RW-1 -: 2]};
    assign trial = {{(MW-SW){1'b0}}, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (ce) begin
        rad_r[j] <= rad_in << 2;
        if (part >= trial) begin
          rem_r[j]  <= MW'(part - trial);
          root_r[j] <= {root_in[SW-2:0], 1'b1};
        end else begin
          rem_r[j]  <= part[MW-1:0];
          root_r[j] <= {root_in[SW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[SW-1];

endmodule
`default_nettype wire

### hdl/tlik_cordic.sv
`default_nettype none
// Vectoring CORDIC atan2, one rotation per stage after a pre-rotation stage
module tlik_cordic #(
  parameter int STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 ce,
  input  wire logic signed [tlik_pkg::CORD_IN_W-1:0] y_in,
  input  wire logic signed [tlik_pkg::CORD_IN_W-1:0] x_in,
  output logic      signed [tlik_pkg::ANG_W-1:0]     z_out
);
  localparam int CW = tlik_pkg::CORD_W;
  localparam int AW = tlik_pkg::ANG_W;

  logic signed [CW-1:0] x_r [STEPS+1];
  logic signed [CW-1:0] y_r [STEPS+1];
  logic signed [AW-1:0] z_r [STEPS+1];

  logic signed [CW-1:0] x_s;
  logic signed [CW-1:0] y_s;

  assign x_s = CW'(x_in) <<< tlik_pkg::CORD_PRE;
  assign y_s = CW'(y_in) <<< tlik_pkg::CORD_PRE;

  // fold the left half-plane over by +-pi
  always_ff @(posedge clk) begin
    if (ce) begin
      if (x_in < 0) begin
        x_r[0] <= -x_s;
        y_r[0] <= -y_s;
        z_r[0] <= (y_in >= 0) ? tlik_pkg::PI_Q30 : -tlik_pkg::PI_Q30;
      end else begin
        x_r[0] <= x_s;
        y_r[0] <= y_s;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [AW-1:0] ATAN = tlik_pkg::atan_step(i);
    // rotate towards the x axis
    always_ff @(posedge clk) begin
      if (ce) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end
      end
    end
  end

  assign z_out = z_r[STEPS];

endmodule
`default_nettype wire

### hdl/two_link_planar_inverse_kinematics.sv
`default_nettype none
// Channel  Dir  Ports                         Payload
// in       in   in_tvalid/tready/tdata[39:0]  target_x, target_y
// out      out  out_tvalid/tready/tdata[63:0] shoulder, elbow, wrist angles
//               out_tuser[0]                  unreachable
// cfg      in   cfg_we/addr/wdata             five registers, write only
//
// One item enters per cycle unless out_tready stalls the pipeline; the stages are three front
// stages, the 21-stage square root, the CORDIC pre-rotation and rotation
// stages, and the combine and output stages.
// rst_n (synchronous) clears the valid bits and resets the configuration registers.
// A stall on out_tready freezes the whole pipeline; nothing is dropped.
module two_link_planar_inverse_kinematics #(
  parameter int FRAC_BITS    = tlik_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // target_x[19:0], target_y[39:20]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // shoulder[20:0], elbow[41:21], wrist[62:42]
  output logic [0:0]       out_tuser,  // unreachable[0]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [19:0] cfg_wdata
);
  localparam int SQ  = tlik_pkg::ROOT_W;
  localparam int NV  = 3 + SQ + CORDIC_STEPS + 1 + 2;
  localparam int SH  = tlik_pkg::ANG_BITS - FRAC_BITS;
  localparam int AW  = 36 + SH;
  localparam int PW  = tlik_pkg::POS_W;
  localparam int UD  = SQ + CORDIC_STEPS + 1;

  // configuration registers
  logic        [18:0] seg_len_r;
  logic        [18:0] tool_len_r;
  logic signed [19:0] front_off_r;
  logic signed [19:0] shoulder_h_r;
  logic signed [19:0] ang_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r    <= tlik_pkg::SEG_LEN_RST;
      tool_len_r   <= '0;
      front_off_r  <= '0;
      shoulder_h_r <= '0;
      ang_off_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        tlik_pkg::REG_SEG_LEN:   seg_len_r    <= cfg_wdata[18:0];
        tlik_pkg::REG_TOOL_LEN:  tool_len_r   <= cfg_wdata[18:0];
        tlik_pkg::REG_FRONT_OFF: front_off_r  <= cfg_wdata;
        tlik_pkg::REG_SHOULDER:  shoulder_h_r <= cfg_wdata;
        tlik_pkg::REG_ANG_OFF:   ang_off_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: the output register frees or is empty
  logic ce;
  logic [NV-1:0] vld_r;

  assign ce        = !vld_r[NV-1] || out_tready;
  assign in_tready = ce;
  assign out_tvalid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (ce) vld_r <= {vld_r[NV-2:0], in_tvalid};
  end

  // stage 1: shoulder coordinates
  logic signed [PW-1:0] x1_r, y1_r;
  logic signed [19:0]   tx, ty;

  assign tx = in_tdata[19:0];
  assign ty = in_tdata[39:20];

  always_ff @(posedge clk) begin
    if (ce) begin
      x1_r <= PW'(tx) + PW'(front_off_r) - PW'(signed'({1'b0, tool_len_r}));
      y1_r <= PW'(shoulder_h_r) - PW'(ty);
    end
  end

  // stage 2: squares
  logic signed [2*PW-1:0] xx2_r, yy2_r;
  logic        [37:0]     ll2_r;
  logic signed [PW-1:0]   x2_r, y2_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      xx2_r <= x1_r * x1_r;
      yy2_r <= y1_r * y1_r;
      ll2_r <= seg_len_r * seg_len_r;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
    end
  end

  // stage 3: radius squared, reach test, remainder for the second root
  logic [tlik_pkg::R2_W-1:0] r2, reach2, r2_3_r, d2_3_r;
  logic                      unr3_r;
  logic signed [PW-1:0]      xd_r [SQ+1];
  logic signed [PW-1:0]      yd_r [SQ+1];

  assign r2     = tlik_pkg::R2_W'(unsigned'(xx2_r)) + tlik_pkg::R2_W'(unsigned'(yy2_r));
  assign reach2 = tlik_pkg::R2_W'({ll2_r, 2'b00});

  always_ff @(posedge clk) begin
    if (ce) begin
      r2_3_r   <= r2;
      d2_3_r   <= reach2 - r2;
      unr3_r   <= (r2 == '0) || (r2 > reach2);
      xd_r[0]  <= x2_r;
      yd_r[0]  <= y2_r;
    end
  end

  // hold x, y alongside the square roots
  for (genvar k = 0; k < SQ; k++) begin : g_xy_dly
    always_ff @(posedge clk) begin
      if (ce) begin
        xd_r[k+1] <= xd_r[k];
        yd_r[k+1] <= yd_r[k];
      end
    end
  end

  logic [SQ-1:0] root_r, root_q;

  tlik_sqrt u_sqrt_r (.clk(clk), .ce(ce), .rad(r2_3_r), .root(root_r));
  tlik_sqrt u_sqrt_q (.clk(clk), .ce(ce), .rad(d2_3_r), .root(root_q));

  // half elbow angle and target bearing
  logic signed [tlik_pkg::ANG_W-1:0] h_z, phi_z;

  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_h (
    .clk(clk), .ce(ce),
    .y_in(tlik_pkg::CORD_IN_W'({1'b0, root_r})),
    .x_in(tlik_pkg::CORD_IN_W'({1'b0, root_q})),
    .z_out(h_z)
  );

  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_phi (
    .clk(clk), .ce(ce),
    .y_in(tlik_pkg::CORD_IN_W'(yd_r[SQ])),
    .x_in(tlik_pkg::CORD_IN_W'(xd_r[SQ])),
    .z_out(phi_z)
  );

  // carry the unreachable flag to the combine stage
  logic unr_d_r [UD];

  always_ff @(posedge clk) begin
    if (ce) unr_d_r[0] <= unr3_r;
  end

  for (genvar k = 1; k < UD; k++) begin : g_unr_dly
    always_ff @(posedge clk) begin
      if (ce) unr_d_r[k] <= unr_d_r[k-1];
    end
  end

  // combine into joint angles, Q30
  logic signed [AW-1:0] off30, hh, pp;
  logic signed [AW-1:0] sho_r, elb_r, wri_r;
  logic                 unr_m_r;

  assign off30 = AW'(ang_off_r) <<< SH;
  assign hh    = AW'(h_z);
  assign pp    = AW'(phi_z);

  always_ff @(posedge clk) begin
    if (ce) begin
      sho_r   <= hh - AW'(tlik_pkg::HALF_PI_Q30) - pp + off30;
      elb_r   <= (hh <<< 1) - AW'(tlik_pkg::PI_Q30);
      wri_r   <= hh - AW'(tlik_pkg::HALF_PI_Q30) - pp
                 - ((hh <<< 1) - AW'(tlik_pkg::PI_Q30));
      unr_m_r <= unr_d_r[UD-1];
    end
  end

  // round to the output format and saturate
  function automatic logic [tlik_pkg::OUT_W-1:0] to_out(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    logic [tlik_pkg::OUT_W-1:0] o;
    t = (v + (AW'(1) <<< (SH - 1))) >>> SH;
    if (t > AW'(1048575)) o = 21'h0FFFFF;
    else if (t < -AW'(1048576)) o = 21'h100000;
    else o = t[tlik_pkg::OUT_W-1:0];
    return o;
  endfunction

  logic [62:0] res_r;
  logic        unr_o_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      unr_o_r <= unr_m_r;
      if (unr_m_r) res_r <= '0;
      else res_r <= {to_out(wri_r), to_out(elb_r), to_out(sho_r)};
    end
  end

  assign out_tdata = {1'b0, res_r};
  assign out_tuser = unr_o_r;

  // an unreachable target gives zero angles
  a_unr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("unreachable item with nonzero angles");

  // an accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item lost at entry");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
